[design/i2cstc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C SCL timing calculator package
// Field widths, protocol limits and the sideband carried through the divider.
// ----------------------------------------------------------------------------
package i2cstc_pkg;

   // Defaults for the top-level parameters
   localparam int unsigned DefClockHz    = 48000000;
   localparam int unsigned DefRiseTimeNs = 100;
   localparam int unsigned DefMaxSpeedHz = 1000000;

   // Field widths
   localparam int unsigned ReqW    = 26;
   localparam int unsigned DivW    = 8;
   localparam int unsigned ActOutW = 23;
   localparam int unsigned LowW    = 16;
   localparam int unsigned MinW    = 13;

   // Timing constants
   localparam int unsigned OvhBase   = 10;
   localparam int unsigned LowBase   = 5;
   localparam int unsigned DivMax    = 255;
   localparam int unsigned LowMax    = 65535;
   localparam int unsigned HzPerMhz  = 1000000;
   localparam int unsigned HzPerKhz  = 1000;
   localparam int unsigned NsPerUs   = 1000;
   localparam int unsigned NsPerMs   = 1000000;

   // Speed bands and minimum SCL low times
   localparam int unsigned StdLimitHz  = 100000;
   localparam int unsigned FastLimitHz = 400000;
   localparam logic [MinW-1:0] MinLowStd   = MinW'(4700);
   localparam logic [MinW-1:0] MinLowFast  = MinW'(1300);
   localparam logic [MinW-1:0] MinLowFplus = MinW'(500);

   // Request classification carried alongside the division
   typedef struct packed {
      logic zero;   // request of zero hertz
      logic sat;    // quotient at or above the saturation point
   } i2cstc_flag_type;

endpackage

[design/i2cstc_div_pipe.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C SCL timing calculator: quotient pipeline
// Restoring division of the clock frequency by the request, one quotient
// bit per stage, with per-stage valid bits and bubble collapsing.
// ----------------------------------------------------------------------------
module i2cstc_div_pipe #(
   parameter int unsigned CLOCK_HZ = i2cstc_pkg::DefClockHz,
   parameter int unsigned QUOT_W   = 10
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic [i2cstc_pkg::ReqW-1:0]   in_den,
   input  i2cstc_pkg::i2cstc_flag_type   in_flag,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic [QUOT_W-1:0]             out_quot,
   output logic [i2cstc_pkg::ReqW-1:0]   out_den,
   output i2cstc_pkg::i2cstc_flag_type   out_flag
);
   import i2cstc_pkg::*;

   localparam int unsigned RemW  = $clog2(CLOCK_HZ + 1);
   localparam int unsigned TrialW = ReqW + QUOT_W;

   // Index 0 is the input side, index k+1 is the output of stage k
   logic [RemW-1:0]    rem_src  [QUOT_W+1];
   logic [QUOT_W-1:0]  quot_src [QUOT_W+1];
   logic [ReqW-1:0]    den_src  [QUOT_W+1];
   i2cstc_flag_type    flag_src [QUOT_W+1];
   logic               v_src    [QUOT_W+1];
   logic               en       [QUOT_W+1];

   assign rem_src[0]  = RemW'(CLOCK_HZ);
   assign quot_src[0] = '0;
   assign den_src[0]  = in_den;
   assign flag_src[0] = in_flag;
   assign v_src[0]    = in_valid;
   assign en[QUOT_W]  = out_ready;
   assign in_ready    = en[0];

   for (genvar k = 0; k < QUOT_W; k++) begin : g_stage
      localparam int unsigned Bit = QUOT_W - 1 - k;

      logic [RemW-1:0]   rem_ff;
      logic [RemW-1:0]   rem_in;
      logic [QUOT_W-1:0] quot_ff;
      logic [QUOT_W-1:0] quot_in;
      logic [ReqW-1:0]   den_ff;
      i2cstc_flag_type   flag_ff;
      logic              v_ff;
      logic [TrialW-1:0] trial;
      logic              ge;

      always_comb begin
         trial   = TrialW'(den_src[k]) << Bit;
         ge      = TrialW'(rem_src[k]) >= trial;
         rem_in  = ge ? RemW'(TrialW'(rem_src[k]) - trial) : rem_src[k];
         quot_in = {quot_src[k][QUOT_W-2:0], ge};
      end

      // Advance when this slot is empty or its contents move on
      assign en[k] = !v_ff || en[k+1];

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff <= 1'b0;
         end else if (en[k]) begin
            v_ff <= v_src[k];
         end
      end

      always_ff @(posedge clock) begin
         if (en[k]) begin
            rem_ff  <= rem_in;
            quot_ff <= quot_in;
            den_ff  <= den_src[k];
            flag_ff <= flag_src[k];
         end
      end

      assign rem_src[k+1]  = rem_ff;
      assign quot_src[k+1] = quot_ff;
      assign den_src[k+1]  = den_ff;
      assign flag_src[k+1] = flag_ff;
      assign v_src[k+1]    = v_ff;
   end

   assign out_valid = v_src[QUOT_W];
   assign out_quot  = quot_src[QUOT_W];
   assign out_den   = den_src[QUOT_W];
   assign out_flag  = flag_src[QUOT_W];

`ifndef SYNTH
   // A ready sink keeps the whole pipe moving
   a_ready_chain: assert property (@(posedge clock) disable iff (reset)
      out_ready |-> in_ready)
      else $error("divider pipe stalled while sink ready");

   // The final remainder is always below the divisor for a real request
   a_rem_below_den: assert property (@(posedge clock) disable iff (reset)
      out_valid && !out_flag.zero && !out_flag.sat
         |-> TrialW'(rem_src[QUOT_W]) < TrialW'(out_den))
      else $error("divider remainder not reduced");

   // A transfer into an empty pipe shows up in the first stage
   a_first_load: assert property (@(posedge clock) disable iff (reset)
      in_valid && in_ready |=> v_src[1])
      else $error("accepted item missing from first stage");
`endif

endmodule

[design/i2c_scl_timing_calc_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C SCL timing calculator
// Turns a requested SCL frequency into the baud divider, the achieved
// frequency, the SCL low time, the band minimum low time and an in-spec flag.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake            Payload
//  req      in         req_valid/req_ready  req_requested_hz
//  rsp      out        rsp_valid/rsp_ready  rsp_baud_divider, rsp_actual_hz,
//                                           rsp_low_time_ns, rsp_min_low_ns,
//                                           rsp_in_spec
//
//  One transfer per cycle on each side unless rsp_ready stalls; the path runs
//  input stage, one-bit-per-stage quotient pipe, divider, lookup, band/check.
//  Every stage has its own valid bit; empty slots are filled during a stall,
//  so req_ready stays high until the pipe is really full.
//  Reset clears the valid bits only; no clearing pass is needed.
// ----------------------------------------------------------------------------
module i2c_scl_timing_calc_unit #(
   parameter int unsigned CLOCK_HZ     = i2cstc_pkg::DefClockHz,
   parameter int unsigned RISE_TIME_NS = i2cstc_pkg::DefRiseTimeNs,
   parameter int unsigned MAX_SPEED_HZ = i2cstc_pkg::DefMaxSpeedHz
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [i2cstc_pkg::ReqW-1:0]      req_requested_hz,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [i2cstc_pkg::DivW-1:0]      rsp_baud_divider,
   output logic [i2cstc_pkg::ActOutW-1:0]   rsp_actual_hz,
   output logic [i2cstc_pkg::LowW-1:0]      rsp_low_time_ns,
   output logic [i2cstc_pkg::MinW-1:0]      rsp_min_low_ns,
   output logic                             rsp_in_spec
);
   import i2cstc_pkg::*;

   localparam int unsigned RiseCyc = ((CLOCK_HZ / HzPerMhz) * RISE_TIME_NS + NsPerUs - 1)
                                     / NsPerUs;
   localparam int unsigned Ovh     = OvhBase + RiseCyc;
   // Quotients at or above SatQ all give the saturated divider
   localparam int unsigned SatQ    = Ovh + 2 * DivMax + 1;
   localparam int unsigned QuotW   = $clog2(SatQ);
   localparam int unsigned MulW    = ReqW + QuotW + 1;
   localparam int unsigned ClkKhzRaw = CLOCK_HZ / HzPerKhz;
   localparam int unsigned ClkKhz  = (ClkKhzRaw == 0) ? 1 : ClkKhzRaw;
   localparam int unsigned ActW    = $clog2(CLOCK_HZ / Ovh + 1);

   // ---------------- input stage ----------------
   logic                s0_v_ff;
   logic [ReqW-1:0]     s0_req_ff;
   logic                s0_en;
   i2cstc_flag_type     s0_flag;
   logic                div_in_ready;

   assign s0_en     = !s0_v_ff || div_in_ready;
   assign req_ready = s0_en;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_v_ff <= 1'b0;
      end else if (s0_en) begin
         s0_v_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (s0_en) begin
         s0_req_ff <= req_requested_hz;
      end
   end

   always_comb begin
      s0_flag.zero = (s0_req_ff == '0);
      s0_flag.sat  = (MulW'(s0_req_ff) * MulW'(SatQ)) <= MulW'(CLOCK_HZ);
   end

   // ---------------- quotient pipe ----------------
   logic                div_out_valid;
   logic [QuotW-1:0]    div_quot;
   logic [ReqW-1:0]     div_den;
   i2cstc_flag_type     div_flag;
   logic                p1_en;

   i2cstc_div_pipe #(
      .CLOCK_HZ (CLOCK_HZ),
      .QUOT_W   (QuotW)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s0_v_ff),
      .in_ready  (div_in_ready),
      .in_den    (s0_req_ff),
      .in_flag   (s0_flag),
      .out_valid (div_out_valid),
      .out_ready (p1_en),
      .out_quot  (div_quot),
      .out_den   (div_den),
      .out_flag  (div_flag)
   );

   // ---------------- divider stage ----------------
   logic              p1_v_ff;
   logic [DivW-1:0]   p1_div_ff;
   logic [DivW-1:0]   p1_div_in;
   logic              p1_zero_ff;
   logic [QuotW-1:0]  p1_excess;
   logic              p2_en;

   assign p1_en = !p1_v_ff || p2_en;

   always_comb begin
      p1_excess = div_quot - QuotW'(Ovh) + QuotW'(1);
      if (div_flag.zero) begin
         p1_div_in = '0;
      end else if (div_flag.sat) begin
         p1_div_in = DivW'(DivMax);
      end else if (div_quot <= QuotW'(Ovh)) begin
         p1_div_in = '0;
      end else begin
         p1_div_in = DivW'(p1_excess >> 1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_v_ff <= 1'b0;
      end else if (p1_en) begin
         p1_v_ff <= div_out_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (p1_en) begin
         p1_div_ff  <= p1_div_in;
         p1_zero_ff <= div_flag.zero;
      end
   end

   // ---------------- lookup stage ----------------
   logic [ActW-1:0]   act_tab [DivMax+1];
   logic [LowW-1:0]   low_tab [DivMax+1];

   for (genvar i = 0; i <= DivMax; i++) begin : g_tab
      localparam longint unsigned ActVal = longint'(CLOCK_HZ) / longint'(Ovh + 2 * i);
      localparam longint unsigned LowRaw = (longint'(LowBase + i) * longint'(NsPerMs))
                                           / longint'(ClkKhz);
      localparam longint unsigned LowVal = (LowRaw > LowMax) ? longint'(LowMax) : LowRaw;
      assign act_tab[i] = ActW'(ActVal);
      assign low_tab[i] = LowW'(LowVal);
   end

   logic              p2_v_ff;
   logic [DivW-1:0]   p2_div_ff;
   logic [ActW-1:0]   p2_act_ff;
   logic [LowW-1:0]   p2_low_ff;
   logic              p3_en;

   assign p2_en = !p2_v_ff || p3_en;

   always_ff @(posedge clock) begin
      if (reset) begin
         p2_v_ff <= 1'b0;
      end else if (p2_en) begin
         p2_v_ff <= p1_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (p2_en) begin
         p2_div_ff <= p1_div_ff;
         p2_act_ff <= act_tab[p1_div_ff];
         p2_low_ff <= low_tab[p1_div_ff];
      end
   end

   // ---------------- band and check stage ----------------
   logic              p3_v_ff;
   logic [DivW-1:0]   p3_div_ff;
   logic [ActW-1:0]   p3_act_ff;
   logic [LowW-1:0]   p3_low_ff;
   logic [MinW-1:0]   p3_min_ff;
   logic [MinW-1:0]   p3_min_in;
   logic              p3_ok_ff;
   logic              p3_ok_in;

   assign p3_en = !p3_v_ff || rsp_ready;

   always_comb begin
      if (32'(p2_act_ff) <= 32'(StdLimitHz)) begin
         p3_min_in = MinLowStd;
      end else if (32'(p2_act_ff) <= 32'(FastLimitHz)) begin
         p3_min_in = MinLowFast;
      end else begin
         p3_min_in = MinLowFplus;
      end
      p3_ok_in = (32'(p2_act_ff) <= 32'(MAX_SPEED_HZ)) &&
                 (p2_low_ff >= LowW'(p3_min_in));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p3_v_ff <= 1'b0;
      end else if (p3_en) begin
         p3_v_ff <= p2_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (p3_en) begin
         p3_div_ff <= p2_div_ff;
         p3_act_ff <= p2_act_ff;
         p3_low_ff <= p2_low_ff;
         p3_min_ff <= p3_min_in;
         p3_ok_ff  <= p3_ok_in;
      end
   end

   assign rsp_valid        = p3_v_ff;
   assign rsp_baud_divider = p3_div_ff;
   assign rsp_actual_hz    = ActOutW'(p3_act_ff);
   assign rsp_low_time_ns  = p3_low_ff;
   assign rsp_min_low_ns   = p3_min_ff;
   assign rsp_in_spec      = p3_ok_ff;

`ifndef SYNTH
   // A ready sink must never back-pressure the request side
   a_no_false_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_ready |-> req_ready)
      else $error("request side stalled with ready sink");

   // In-spec results always meet the band minimum
   a_in_spec_low: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_in_spec |-> LowW'(rsp_min_low_ns) <= rsp_low_time_ns)
      else $error("in-spec flag set below minimum low time");

   // A zero request gives a zero divider
   a_zero_div: assert property (@(posedge clock) disable iff (reset)
      p1_v_ff && p1_zero_ff |-> p1_div_ff == '0)
      else $error("zero request produced nonzero divider");

   // The divider passes from the lookup stage to the output unchanged
   a_div_carry: assert property (@(posedge clock) disable iff (reset)
      p2_v_ff && p3_en |=> p3_v_ff && (p3_div_ff == $past(p2_div_ff)))
      else $error("divider lost between lookup and output");
`endif

endmodule
